// ===== rtl/core/cpd_pkg.sv =====
// Shared types and codes for the game-port dongle model.
package cpd_pkg;

	typedef enum logic [2:0] {
		KIND_NONE    = 3'd0,
		KIND_ROBOCOP = 3'd1,
		KIND_BAT     = 3'd2,
		KIND_CRICKET = 3'd3,
		KIND_LEADER  = 3'd4,
		KIND_RUGBY   = 3'd5,
		KIND_STRIKER = 3'd6
	} cpd_kind_t;

	typedef enum logic [1:0] {
		CMD_CIA_WRITE = 2'd0,
		CMD_CIA_READ  = 2'd1,
		CMD_JOY_READ  = 2'd2,
		CMD_POTGO     = 2'd3
	} cpd_cmd_t;

	typedef struct packed {
		logic [7:0]  control_count;
		logic [31:0] stamp_cycle;
	} cpd_state_t;

	localparam logic [15:0] CIA_PA7_MASK   = 16'h0080;
	localparam logic [15:0] BAT_RESP_BIT   = 16'h0010;
	localparam logic [31:0] BAT_TIMEOUT    = 32'h0000_00e2;
	localparam logic [15:0] ROBOCOP_ADD    = 16'h0100;
	localparam logic [15:0] JOY_MASK       = 16'h0303;
	localparam logic [15:0] LEADER_PATTERN = 16'h0101;
	localparam logic [15:0] RUGBY_PATTERN  = 16'h0301;
	localparam logic [15:0] STRIKER_HIGH   = 16'h0203;
	localparam logic [15:0] STRIKER_LOW    = 16'h0200;
	localparam logic [15:0] POTGO_MASK     = 16'h0500;
	localparam logic [15:0] CRICKET_MASK   = 16'h0003;
	localparam logic [7:0]  COUNT_MAX      = 8'hff;
	localparam logic [7:0]  STRIKER_LIMIT  = 8'd4;

endpackage

// ===== rtl/core/cpd_patch.sv =====
// Combinational dongle rule: patched port value and next dongle state.
module cpd_patch (
	input  cpd_pkg::cpd_kind_t  kind,
	input  cpd_pkg::cpd_cmd_t   command,
	input  logic                second_unit,
	input  logic [15:0]         data_in,
	input  logic [31:0]         now_cycle,
	input  cpd_pkg::cpd_state_t state_cur,
	output logic [15:0]         data_out,
	output cpd_pkg::cpd_state_t state_nxt
);
	import cpd_pkg::*;

	logic [7:0]  cnt;
	logic [31:0] elapsed;
	logic        cnt_zero;

	assign cnt      = state_cur.control_count;
	assign cnt_zero = (cnt == 8'd0);
	assign elapsed  = now_cycle - state_cur.stamp_cycle;

	always_comb begin
		data_out  = data_in;
		state_nxt = state_cur;
		case (command)
			CMD_CIA_WRITE: begin
				if (kind == KIND_ROBOCOP && !second_unit) begin
					if ((data_in & CIA_PA7_MASK) != 16'd0) begin
						state_nxt.control_count = cnt ^ 8'd1;
					end
				end else if (kind == KIND_BAT && second_unit) begin
					if ((data_in & CIA_PA7_MASK) == 16'd0) begin
						state_nxt.control_count = 8'd1;
						state_nxt.stamp_cycle   = now_cycle;
					end
				end
			end
			CMD_CIA_READ: begin
				if (kind == KIND_BAT && second_unit) begin
					if (cnt_zero || elapsed > BAT_TIMEOUT) begin
						data_out                = data_in & ~BAT_RESP_BIT;
						state_nxt.control_count = 8'd0;
					end else begin
						data_out = data_in | BAT_RESP_BIT;
					end
				end
			end
			CMD_JOY_READ: begin
				case (kind)
					KIND_ROBOCOP: begin
						if (second_unit && !cnt_zero) begin
							data_out = data_in + ROBOCOP_ADD;
						end
					end
					KIND_CRICKET: begin
						if (!second_unit) begin
							data_out = (data_in & ~CRICKET_MASK)
								| (cnt_zero ? 16'd1 : 16'd2);
						end
						state_nxt.control_count = cnt ^ 8'd1;
					end
					KIND_LEADER: begin
						if (second_unit) begin
							data_out = (data_in & ~JOY_MASK) | LEADER_PATTERN;
						end
					end
					KIND_RUGBY: begin
						if (second_unit) begin
							data_out = (data_in & ~JOY_MASK) | RUGBY_PATTERN;
						end
					end
					KIND_STRIKER: begin
						if (second_unit) begin
							if (cnt >= STRIKER_LIMIT) begin
								data_out                = (data_in & ~JOY_MASK) | STRIKER_HIGH;
								state_nxt.control_count = cnt - 8'd1;
							end else if (!cnt_zero) begin
								data_out = (data_in & ~JOY_MASK) | STRIKER_LOW;
							end
						end
					end
					default: begin
						data_out = data_in;
					end
				endcase
			end
			default: begin
				// pot-go write: striker counts up on both bits, else down, saturating
				if (kind == KIND_STRIKER) begin
					if ((data_in & POTGO_MASK) == POTGO_MASK) begin
						if (cnt != COUNT_MAX) begin
							state_nxt.control_count = cnt + 8'd1;
						end
					end else if (!cnt_zero) begin
						state_nxt.control_count = cnt - 8'd1;
					end
				end
			end
		endcase
	end

endmodule

// ===== rtl/core/copy_protection_dongle_model_top.sv =====
// Top level of the game-port copy-protection dongle model.
//
// Usage: each item on the slave stream describes one machine access.
//   s_tuser carries the access kind and the unit select, s_tdata carries the
//   port value and the machine cycle count. Every item gives exactly one
//   item on the master stream carrying the port value after the dongle's
//   patch (writes come back unchanged).
// The dongle kind sits in a single register written through cfg_we and
//   cfg_wdata; write it only while no item is in flight.
// Timing: an accepted item passes through the input register, then the result
//   register, before it shows on the master stream. Throughput: one item per
//   cycle while m_tready stays high, kept by updating the counter and cycle
//   stamp as an item moves from the input register into the result register.
// Reset (arst_n low): both stages empty, kind none, counter and stamp zero.
// Stall: while m_tready is low the result register holds; the input
//   register still takes one more item, then s_tready drops until the
//   receiver frees the result register.
module copy_protection_dongle_model_top (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_we,
	input  logic [2:0]  cfg_wdata,   // dongle_type
	// slave stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,     // [15:0] data_in, [47:16] now_cycle
	input  logic [2:0]  s_tuser,     // [1:0] command, [2] second_unit
	// master stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata      // [15:0] data_out
);
	import cpd_pkg::*;

	cpd_kind_t  kind_q;
	cpd_state_t state_q;
	cpd_state_t state_nxt;

	// input stage
	logic        valid_s1;
	cpd_cmd_t    cmd_s1;
	logic        unit_s1;
	logic [15:0] data_s1;
	logic [31:0] now_s1;

	// result stage
	logic        valid_s2;
	logic [15:0] result_s2;
	logic [15:0] patched;

	logic        out_free;
	logic        fire_s1;
	logic        take_in;

	// result register frees when empty or being taken this cycle
	assign out_free = !valid_s2 || m_tready;
	assign fire_s1  = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;
	assign take_in  = s_tvalid && s_tready;

	assign m_tvalid = valid_s2;
	assign m_tdata  = result_s2;

	// dongle kind register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= KIND_NONE;
		end else if (cfg_we) begin
			kind_q <= cpd_kind_t'(cfg_wdata);
		end
	end

	// capture the access into the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			cmd_s1  <= cpd_cmd_t'(s_tuser[1:0]);
			unit_s1 <= s_tuser[2];
			data_s1 <= s_tdata[15:0];
			now_s1  <= s_tdata[47:16];
		end
	end

	cpd_patch u_patch (
		.kind        (kind_q),
		.command     (cmd_s1),
		.second_unit (unit_s1),
		.data_in     (data_s1),
		.now_cycle   (now_s1),
		.state_cur   (state_q),
		.data_out    (patched),
		.state_nxt   (state_nxt)
	);

	// advance the dongle state only as an item leaves the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (fire_s1) begin
			state_q <= state_nxt;
		end
	end

	// result register: load on advance, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			result_s2 <= patched;
		end
	end

	// an empty result register never blocks the input side
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with an empty result register");

	// writes come back unchanged
	a_write_passthrough: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 && (cmd_s1 == CMD_CIA_WRITE || cmd_s1 == CMD_POTGO)
		|=> m_tvalid && m_tdata == $past(data_s1))
		else $error("write access altered its port value");

	// dongle state moves only when an item is processed
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!fire_s1 |=> $stable(state_q))
		else $error("dongle state changed without an item");

	// the cycle stamp is only taken by a second-unit write in bat mode
	a_stamp_source: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 && !(kind_q == KIND_BAT && cmd_s1 == CMD_CIA_WRITE && unit_s1)
		|=> $stable(state_q.stamp_cycle))
		else $error("cycle stamp changed outside a bat arming write");

endmodule
